// ===== src/peak_window_interval_count_top_defines.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clock and reset in the using scope.
`ifndef PEAK_WINDOW_INTERVAL_COUNT_TOP_DEFINES_SVH
`define PEAK_WINDOW_INTERVAL_COUNT_TOP_DEFINES_SVH

// same-cycle implication
`define PWIC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pwic check failed");

// next-cycle implication
`define PWIC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pwic check failed");

`endif

// ===== src/pwic_pkg.sv =====
package pwic_pkg;

   localparam int MAX_RECORDS = 2048;
   localparam int WINDOW_MS   = 1000;

   localparam int END_W   = 27;
   localparam int DUR_W   = 14;
   // start runs from -16382 up to 2^27 (zero duration at the top end)
   localparam int START_W = 29;
   localparam int PEAK_W  = 12;
   localparam int PEAK_SAT = 4095;

   // record count must hold MAX_RECORDS itself
   localparam int CNT_W   = $clog2(MAX_RECORDS + 1);
   localparam int ADDR_W  = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
   localparam int ENTRY_W = START_W + END_W;

   typedef logic [END_W-1:0]   end_type;
   typedef logic [DUR_W-1:0]   dur_type;
   typedef logic [START_W-1:0] start_type;
   typedef logic [PEAK_W-1:0]  peak_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ADDR_W-1:0]  addr_type;

   function automatic peak_type sat_peak(input cnt_type best);
      if (32'(best) > 32'(PEAK_SAT)) begin
         return peak_type'(PEAK_SAT);
      end
      return peak_type'(best);
   endfunction

endpackage

// ===== src/pwic_if.sv =====
interface pwic_req_if import pwic_pkg::*; ();
   logic    valid;
   logic    ready;
   end_type end_time_ms;
   dur_type duration_ms;
   logic    last_item;

   modport source (output valid, output end_time_ms, output duration_ms,
                   output last_item, input ready);
   modport sink   (input valid, input end_time_ms, input duration_ms,
                   input last_item, output ready);
endinterface

interface pwic_rsp_if import pwic_pkg::*; ();
   logic     valid;
   logic     ready;
   peak_type peak_count;
   logic     overflow;

   modport source (output valid, output peak_count, output overflow, input ready);
   modport sink   (input valid, input peak_count, input overflow, output ready);
endinterface

// ===== src/peak_window_interval_count_top.sv =====
// Peak window interval count. Each request beat carries one log record (end
// time and duration in ms); the block stores the closed interval
// [end - duration + 1, end] at one record per cycle. A beat with last_item
// set is stored too, then request ready drops and the block scans: for every
// stored start time s it counts the intervals that touch [s - 999, s] and
// keeps the largest count. One response beat then carries that peak
// (saturated at 4095) and the overflow flag, which is set when records
// arrived after the store was full and were dropped. After the response is
// loaded the record count clears and a new set begins. The scan reads the
// stored entries one per cycle through the single, registered read port of
// the record memory. A pending response does not block loading of the
// next set.
module peak_window_interval_count_top import pwic_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   pwic_req_if.sink   req_ch,
   pwic_rsp_if.source rsp_ch
);

   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,   // taking records
      ST_FETCH = 5'b00010,   // read of entry i in flight
      ST_RIGHT = 5'b00100,   // entry i on read port: latch window edges
      ST_SCAN  = 5'b01000,   // walk j over all entries
      ST_DONE  = 5'b10000    // hand peak to output register
   } state_type;

   state_type state_ff, state_in;

   cnt_type   count_ff, count_in;     // stored records
   logic      ovf_seen_ff, ovf_seen_in;
   cnt_type   i_ff, i_in;             // window index
   cnt_type   j_ff, j_in;             // entry index being read
   cnt_type   hits_ff, hits_in;
   cnt_type   best_ff, best_in;
   start_type right_ff, right_in;
   start_type left_ff, left_in;

   logic      rsp_valid_ff, rsp_valid_in;
   peak_type  peak_ff, peak_in;
   logic      ovf_out_ff, ovf_out_in;

   // record memory: {start, end}
   logic                 wr_en;
   addr_type             wr_addr;
   logic [ENTRY_W-1:0]   wr_data;
   addr_type             rd_addr;
   logic [ENTRY_W-1:0]   rd_data;

   pwic_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_RECORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   start_type rec_start;
   start_type rd_start;
   end_type   rd_end;
   logic      hit;
   cnt_type   hits_sum;
   cnt_type   i_next;
   logic      accept;

   assign accept = req_ch.valid && req_ch.ready;

   // start may go negative, or reach 2^27 with zero duration at the top end;
   // START_W-bit two's complement covers every case
   assign rec_start = {{(START_W-END_W){1'b0}}, req_ch.end_time_ms}
                      - {{(START_W-DUR_W){1'b0}}, req_ch.duration_ms}
                      + start_type'(1);

   assign rd_start = rd_data[ENTRY_W-1 -: START_W];
   assign rd_end   = rd_data[END_W-1:0];

   // interval [a, b] touches window [left, right] when a <= right and b >= left
   assign hit = ($signed(rd_start) <= $signed(right_ff)) &&
                ($signed({{(START_W-END_W){1'b0}}, rd_end}) >= $signed(left_ff));
   assign hits_sum = hits_ff + cnt_type'(hit);
   assign i_next   = i_ff + cnt_type'(1);

   assign req_ch.ready      = (state_ff == ST_LOAD);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.peak_count = peak_ff;
   assign rsp_ch.overflow   = ovf_out_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_seen_in  = ovf_seen_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      hits_in      = hits_ff;
      best_in      = best_ff;
      right_in     = right_ff;
      left_in      = left_ff;
      peak_in      = peak_ff;
      ovf_out_in   = ovf_out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      wr_en   = 1'b0;
      wr_addr = count_ff[ADDR_W-1:0];
      wr_data = {rec_start, req_ch.end_time_ms};
      rd_addr = i_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (count_ff < cnt_type'(MAX_RECORDS)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + cnt_type'(1);
               end else begin
                  ovf_seen_in = 1'b1;
               end
               if (req_ch.last_item) begin
                  i_in     = '0;
                  best_in  = '0;
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            rd_addr  = i_ff[ADDR_W-1:0];
            state_in = ST_RIGHT;
         end
         ST_RIGHT: begin
            right_in = rd_start;
            left_in  = rd_start - start_type'(WINDOW_MS - 1);
            rd_addr  = '0;
            j_in     = cnt_type'(1);
            hits_in  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // rd_data holds entry j - 1
            if (j_ff == count_ff) begin
               best_in = (hits_sum > best_ff) ? hits_sum : best_ff;
               if (i_next == count_ff) begin
                  state_in = ST_DONE;
               end else begin
                  i_in     = i_next;
                  rd_addr  = i_next[ADDR_W-1:0];
                  state_in = ST_RIGHT;
               end
            end else begin
               rd_addr = j_ff[ADDR_W-1:0];
               j_in    = j_ff + cnt_type'(1);
               hits_in = hits_sum;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               peak_in      = sat_peak(best_ff);
               ovf_out_in   = ovf_seen_ff;
               rsp_valid_in = 1'b1;
               count_in     = '0;
               ovf_seen_in  = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_seen_ff  <= ovf_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      hits_ff    <= hits_in;
      best_ff    <= best_in;
      right_ff   <= right_in;
      left_ff    <= left_in;
      peak_ff    <= peak_in;
      ovf_out_ff <= ovf_out_in;
   end

endmodule

// ===== src/pwic_ram.sv =====
module pwic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/pwic_checker.sv =====
`include "peak_window_interval_count_top_defines.svh"

module pwic_checker import pwic_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     req_last,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input peak_type rsp_peak,
   input logic     rsp_overflow
);

   // stalled response holds
   `PWIC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_peak) && $stable(rsp_overflow))

   // last record starts the scan: no more records taken next cycle
   `PWIC_ASSERT_NEXT(a_scan_blocks, req_valid && req_ready && req_last, !req_ready)

   // ordinary records keep the load side open
   `PWIC_ASSERT_NEXT(a_load_open, req_valid && req_ready && !req_last, req_ready)

   // a fresh response comes only out of a scan
   `PWIC_ASSERT_NOW(a_rsp_after_scan, $rose(rsp_valid), !$past(req_ready))

endmodule

bind peak_window_interval_count_top pwic_checker u_pwic_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .req_last     (req_ch.last_item),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_peak     (rsp_ch.peak_count),
   .rsp_overflow (rsp_ch.overflow)
);
